>>> rtl/dps_pkg.sv
// Shared types and constants of the diphoton event selector.
package dps_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_CUT_ENABLES    = 3'd0;
    localparam logic [2:0] CFG_MIN_ET_FIRST   = 3'd1;
    localparam logic [2:0] CFG_MIN_ET_SECOND  = 3'd2;
    localparam logic [2:0] CFG_MAX_ETA_FIRST  = 3'd3;
    localparam logic [2:0] CFG_MAX_ETA_SECOND = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // cut_enables bit positions
    localparam int EN_FILTER   = 0;
    localparam int EN_ISO_FIRST  = 1;
    localparam int EN_ISO_SECOND = 2;
    localparam int EN_ID_FIRST   = 3;
    localparam int EN_ID_SECOND  = 4;

    // Reset values
    localparam logic [4:0]  CUT_ENABLES_RST = 5'd1;
    localparam logic [12:0] MAX_ETA_RST     = 13'd3072;

    // Cut set configuration seen by the classifier
    typedef struct packed {
        logic [4:0]  cut_enables;
        logic [15:0] min_et_first;
        logic [15:0] min_et_second;
        logic [12:0] max_eta_first;
        logic [12:0] max_eta_second;
    } cfg_t;

    // Outcome of one photon, passed from classifier to accumulator
    typedef struct packed {
        logic pass_first;
        logic pass_second;
        logic last;
    } cls_t;

endpackage

>>> rtl/dps_photon_if.sv
// Photon candidate channel and event result channel.
interface dps_photon_if;
    logic               valid;
    logic               ready;
    logic [15:0]        photon_pt;
    logic [15:0]        ecal_iso_sum;
    logic [15:0]        hcal_iso_sum;
    logic [15:0]        track_iso_sum;
    logic [15:0]        shower_width;
    logic               in_barrel;
    logic               in_endcap;
    logic [15:0]        had_over_em;
    logic signed [13:0] cluster_eta;
    logic [15:0]        cluster_et;
    logic               last_in_event;

    modport source (
        output valid, photon_pt, ecal_iso_sum, hcal_iso_sum, track_iso_sum,
               shower_width, in_barrel, in_endcap, had_over_em, cluster_eta,
               cluster_et, last_in_event,
        input  ready
    );
    modport sink (
        input  valid, photon_pt, ecal_iso_sum, hcal_iso_sum, track_iso_sum,
               shower_width, in_barrel, in_endcap, had_over_em, cluster_eta,
               cluster_et, last_in_event,
        output ready
    );
endinterface

interface dps_result_if;
    logic       valid;
    logic       ready;
    logic       event_accept;
    logic [1:0] passing_count;

    modport source (output valid, event_accept, passing_count, input ready);
    modport sink   (input valid, event_accept, passing_count, output ready);
endinterface

>>> rtl/dps_front.sv
// Classifier: accepts photons and registers the pass flags of both cut sets.
module dps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dps_pkg::cfg_t       cfg,
    dps_photon_if.sink          photon,
    output logic                cls_valid,
    input  logic                cls_ready,
    output dps_pkg::cls_t       cls
);

    logic          cls_valid_reg;
    logic          cls_valid_next;
    dps_pkg::cls_t cls_reg;
    dps_pkg::cls_t cls_next;

    logic [26:0] ecal_lhs;
    logic [26:0] ecal_rhs;
    logic [27:0] hcal_lhs;
    logic [27:0] hcal_rhs;
    logic [26:0] trk_lhs;
    logic [26:0] trk_rhs;
    logic [25:0] width_lhs;
    logic [5:0]  sieie_units;
    logic [25:0] width_rhs;
    logic [20:0] hoe_lhs;
    logic [13:0] abs_eta;
    logic        iso_ok;
    logic        id_ok;
    logic        iso1;
    logic        iso2;
    logic        id1;
    logic        id2;
    logic        take;

    // Isolation: constant multiplies against linear-in-pt thresholds
    assign ecal_lhs = 27'(photon.ecal_iso_sum) * 27'd1000;
    assign ecal_rhs = 27'd100800 + 27'(photon.photon_pt) * 27'd9;
    assign hcal_lhs = 28'(photon.hcal_iso_sum) * 28'd4000;
    assign hcal_rhs = 28'd211200 + 28'(photon.photon_pt) * 28'd15;
    assign trk_lhs  = 27'(photon.track_iso_sum) * 27'd2000;
    assign trk_rhs  = 27'd168000 + 27'(photon.photon_pt) * 27'd3;

    assign iso_ok = (ecal_lhs < ecal_rhs) && (hcal_lhs < hcal_rhs) && (trk_lhs < trk_rhs);

    // Shower width limit: barrel and endcap limits add when both flags are set
    assign sieie_units = (photon.in_barrel ? 6'd13 : 6'd0) + (photon.in_endcap ? 6'd30 : 6'd0);
    assign width_rhs   = {4'd0, sieie_units, 16'd0};
    assign width_lhs   = 26'(photon.shower_width) * 26'd1000;
    assign hoe_lhs     = 21'(photon.had_over_em) * 21'd20;

    assign id_ok = (width_lhs < width_rhs) && (hoe_lhs < 21'd4096);

    // Magnitude of eta; the most negative code maps to 8192
    assign abs_eta = photon.cluster_eta[13] ? 14'(-photon.cluster_eta)
                                            : 14'(photon.cluster_eta);

    assign iso1 = !cfg.cut_enables[dps_pkg::EN_ISO_FIRST]  || iso_ok;
    assign iso2 = !cfg.cut_enables[dps_pkg::EN_ISO_SECOND] || iso_ok;
    assign id1  = !cfg.cut_enables[dps_pkg::EN_ID_FIRST]   || id_ok;
    assign id2  = !cfg.cut_enables[dps_pkg::EN_ID_SECOND]  || id_ok;

    // Output stage: refill whenever empty or draining this cycle
    assign photon.ready = !cls_valid_reg || cls_ready;
    assign take         = photon.valid && photon.ready;

    always_comb
    begin
        cls_next             = cls_reg;
        cls_valid_next       = cls_valid_reg && !cls_ready;
        if (take)
        begin
            cls_valid_next       = 1'b1;
            cls_next.pass_first  = iso1 && id1
                                   && (abs_eta < {1'b0, cfg.max_eta_first})
                                   && (photon.cluster_et > cfg.min_et_first);
            cls_next.pass_second = iso2 && id2
                                   && (abs_eta < {1'b0, cfg.max_eta_second})
                                   && (photon.cluster_et > cfg.min_et_second);
            cls_next.last        = photon.last_in_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else
        begin
            cls_valid_reg <= cls_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign cls_valid = cls_valid_reg;
    assign cls       = cls_reg;

endmodule

>>> rtl/dps_queue.sv
// Short queue of classified photons between classifier and accumulator.
module dps_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  dps_pkg::cls_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output dps_pkg::cls_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dps_pkg::cls_t     mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dps_back.sv
// Accumulator: sticky pass flags, saturating tally and the event result register.
module dps_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          filter_on,
    input  logic          cls_valid,
    output logic          cls_ready,
    input  dps_pkg::cls_t cls,
    dps_result_if.source  result
);

    logic       seen_first_reg;
    logic       seen_first_next;
    logic       seen_second_reg;
    logic       seen_second_next;
    logic [1:0] tally_reg;
    logic [1:0] tally_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept_reg;
    logic       accept_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    logic       slot_free;
    logic       take;
    logic       upd_first;
    logic       upd_second;
    logic [1:0] upd_tally;

    // A last photon needs room in the result register; others always go
    assign slot_free = !out_valid_reg || result.ready;
    assign cls_ready = !cls.last || slot_free;
    assign take      = cls_valid && cls_ready;

    assign upd_first  = seen_first_reg || cls.pass_first;
    assign upd_second = seen_second_reg || cls.pass_second;
    assign upd_tally  = ((cls.pass_first || cls.pass_second) && (tally_reg != 2'd2))
                        ? tally_reg + 2'd1 : tally_reg;

    // Event state update
    always_comb
    begin
        seen_first_next  = seen_first_reg;
        seen_second_next = seen_second_reg;
        tally_next       = tally_reg;
        if (take)
        begin
            if (cls.last)
            begin
                seen_first_next  = 1'b0;
                seen_second_next = 1'b0;
                tally_next       = 2'd0;
            end
            else
            begin
                seen_first_next  = upd_first;
                seen_second_next = upd_second;
                tally_next       = upd_tally;
            end
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        accept_next    = accept_reg;
        count_next     = count_reg;
        if (take && cls.last)
        begin
            out_valid_next = 1'b1;
            accept_next    = !filter_on || (upd_first && upd_second && (upd_tally == 2'd2));
            count_next     = upd_tally;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg  <= 1'b0;
            seen_second_reg <= 1'b0;
            tally_reg       <= 2'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seen_first_reg  <= seen_first_next;
            seen_second_reg <= seen_second_next;
            tally_reg       <= tally_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accept_reg <= accept_next;
        count_reg  <= count_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.event_accept  = accept_reg;
    assign result.passing_count = count_reg;

endmodule

>>> rtl/diphoton_event_selector.sv
// Top level of the diphoton event selector: config registers, classifier, queue, accumulator.
//
// Channel   Dir  Transfer rule        Payload
// photon    in   valid & ready        one photon candidate, last_in_event closes the event
// result    out  valid & ready        event_accept, passing_count (one per event)
// cfg       in   cfg_we at clock edge cut_enables, Et minimums, eta limits by index
//
// Throughput is one photon per cycle while the queue has room; all cuts are combinational.
// A result becomes valid once its last photon has passed the classifier register (loaded at
// the transfer edge), then the queue, then the result register.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled result holds back a last photon at the queue head; the queue takes others until full.
module diphoton_event_selector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dps_photon_if.sink                        photon,
    dps_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [dps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dps_pkg::cfg_t cfg_reg;
    dps_pkg::cfg_t cfg_next;

    logic          fr_valid;
    logic          fr_ready;
    dps_pkg::cls_t fr_cls;
    logic          bk_valid;
    logic          bk_ready;
    dps_pkg::cls_t bk_cls;

    // Configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dps_pkg::CFG_CUT_ENABLES:    cfg_next.cut_enables    = cfg_data[4:0];
                dps_pkg::CFG_MIN_ET_FIRST:   cfg_next.min_et_first   = cfg_data;
                dps_pkg::CFG_MIN_ET_SECOND:  cfg_next.min_et_second  = cfg_data;
                dps_pkg::CFG_MAX_ETA_FIRST:  cfg_next.max_eta_first  = cfg_data[12:0];
                dps_pkg::CFG_MAX_ETA_SECOND: cfg_next.max_eta_second = cfg_data[12:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_enables    <= dps_pkg::CUT_ENABLES_RST;
            cfg_reg.min_et_first   <= '0;
            cfg_reg.min_et_second  <= '0;
            cfg_reg.max_eta_first  <= dps_pkg::MAX_ETA_RST;
            cfg_reg.max_eta_second <= dps_pkg::MAX_ETA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .photon    (photon),
        .cls_valid (fr_valid),
        .cls_ready (fr_ready),
        .cls       (fr_cls)
    );

    dps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_cls),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_cls)
    );

    dps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .filter_on (cfg_reg.cut_enables[dps_pkg::EN_FILTER]),
        .cls_valid (bk_valid),
        .cls_ready (bk_ready),
        .cls       (bk_cls),
        .result    (result)
    );

endmodule

>>> rtl/dps_checker.sv
// Port-level checks of the diphoton event selector, bound to the top level.
module dps_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             in_last,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             out_accept,
    input logic [1:0]                       out_count,
    input logic                             cfg_we,
    input logic [dps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [dps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic       filter_on_reg;
    logic [7:0] pending_reg;
    logic       in_last_xfer;
    logic       out_xfer;

    assign in_last_xfer = in_valid && in_ready && in_last;
    assign out_xfer     = out_valid && out_ready;

    // Shadow of the filter enable bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_on_reg <= 1'b1;
        end
        else if (cfg_we && (cfg_index == dps_pkg::CFG_CUT_ENABLES))
        begin
            filter_on_reg <= cfg_data[dps_pkg::EN_FILTER];
        end
    end

    // Events closed at the input but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, in_last_xfer} - {7'd0, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count != 2'd3)
        else $error("passing_count above saturation");

    a_accept_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filter_on_reg && out_accept |-> out_count == 2'd2)
        else $error("event accepted with fewer than two passing photons");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result without a closed event");

endmodule

bind diphoton_event_selector dps_checker u_dps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (photon.valid),
    .in_ready   (photon.ready),
    .in_last    (photon.last_in_event),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_accept (result.event_accept),
    .out_count  (result.passing_count),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);
